// ----- hdl/utf8_overlap_text_chunker_defines.svh -----
// Assertion macros for the chunker. Each expects clk and rst in scope.
`ifndef UTF8_OVERLAP_TEXT_CHUNKER_DEFINES_SVH
`define UTF8_OVERLAP_TEXT_CHUNKER_DEFINES_SVH

`define UOTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chunker assertion failed");

`define UOTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chunker assertion failed");

`endif

// ----- hdl/uotc_pkg.sv -----
package uotc_pkg;

  localparam int OPEN_WINDOWS = 8;
  localparam int CNT_W        = $clog2(OPEN_WINDOWS + 1);
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int Q_CW         = $clog2(Q_DEPTH + 1);
  localparam int CFG_W        = 12;

  localparam logic [CFG_W-1:0] CHUNK_RESET   = 12'd512;
  localparam logic [CFG_W-1:0] OVERLAP_RESET = 12'd0;

  localparam logic [7:0] LEAD_MASK = 8'hC0;
  localparam logic [7:0] CONT_CODE = 8'h80;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [0:0] {
    REG_CHUNK_CHARS   = 1'b0,
    REG_OVERLAP_CHARS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        valid;
    logic        seen;
    logic [31:0] start_char;
    logic [31:0] first_off;
    logic [31:0] end_off;
  } slot_t;

  typedef struct packed {
    logic        en;
    logic        clear;
    logic        shift;
    logic        join_byte;
    logic [31:0] offset;
    logic [31:0] start_char;
  } cell_ctl_t;

  typedef struct packed {
    logic [31:0] chunk_number;
    logic [31:0] begin_offset;
    logic [31:0] end_offset;
    logic        final_chunk;
    logic        window_dropped;
    logic        last_in_run;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  endfunction

endpackage

// ----- hdl/uotc_cell.sv -----
module uotc_cell (
  input  logic              clk,
  input  logic              rst,
  input  uotc_pkg::cell_ctl_t ctl,
  input  logic              open_here,
  input  uotc_pkg::slot_t   nbr,
  output uotc_pkg::slot_t   cur,
  output uotc_pkg::slot_t   upd
);

  always_comb begin
    upd = ctl.shift ? nbr : cur;
    if (open_here) begin
      upd.valid      = 1'b1;
      upd.seen       = 1'b0;
      upd.start_char = ctl.start_char;
      upd.first_off  = 32'd0;
      upd.end_off    = 32'd0;
    end
    if (ctl.join_byte && upd.valid) begin
      if (!upd.seen) begin
        upd.seen      = 1'b1;
        upd.first_off = ctl.offset;
      end
      upd.end_off = ctl.offset + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      cur.seen  <= 1'b0;
    end else if (ctl.en) begin
      cur <= upd;
      if (ctl.clear) begin
        cur.valid <= 1'b0;
        cur.seen  <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/uotc_out_queue.sv -----
module uotc_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_a,
  input  uotc_pkg::result_t rec_a,
  input  logic              push_b,
  input  uotc_pkg::result_t rec_b,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output uotc_pkg::result_t head,
  output logic [uotc_pkg::Q_CW-1:0] fill
);

  uotc_pkg::result_t              mem [uotc_pkg::Q_DEPTH];
  logic [uotc_pkg::Q_AW-1:0]      wr_ptr;
  logic [uotc_pkg::Q_AW-1:0]      rd_ptr;
  logic [uotc_pkg::Q_AW-1:0]      wr_b;
  logic                           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != '0;
  assign head      = mem[rd_ptr];
  assign room      = fill <= uotc_pkg::Q_CW'(uotc_pkg::Q_DEPTH - 2);
  assign wr_b      = push_a ? wr_ptr + uotc_pkg::Q_AW'(1) : wr_ptr;

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= rec_a;
    end
    if (push_b) begin
      mem[wr_b] <= rec_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + uotc_pkg::Q_AW'(push_a) + uotc_pkg::Q_AW'(push_b);
      if (pop) begin
        rd_ptr <= rd_ptr + uotc_pkg::Q_AW'(1);
      end
      fill <= fill + uotc_pkg::Q_CW'(push_a) + uotc_pkg::Q_CW'(push_b)
              - uotc_pkg::Q_CW'(pop);
    end
  end

endmodule

// ----- hdl/utf8_overlap_text_chunker.sv -----
// Splits a UTF-8 document, taken one byte per word, into overlapping windows of
// chunk_chars characters that advance by chunk_chars minus overlap_chars, and
// reports each non-empty window's trimmed byte range. A byte is taken every
// cycle while in_ready is high: a row of eight window cells, oldest first,
// updates in parallel and shifts to the head when the oldest window closes.
// Results are written to a four-word output queue with their byte; in_ready
// drops while the queue has fewer than two free places, so a byte that closes
// one window and ends the document (two words) finds room for both. More than
// eight windows open at once are dropped and reported through window_dropped.
`include "utf8_overlap_text_chunker_defines.svh"

module utf8_overlap_text_chunker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_document,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] chunk_number,
  output logic [31:0] begin_offset,
  output logic [31:0] end_offset,
  output logic        final_chunk,
  output logic        window_dropped,
  output logic        last_in_run
);

  localparam int N = uotc_pkg::OPEN_WINDOWS;
  localparam int CW = uotc_pkg::CNT_W;

  logic [uotc_pkg::CFG_W-1:0] chunk_chars;
  logic [uotc_pkg::CFG_W-1:0] overlap_chars;
  logic [uotc_pkg::CFG_W-1:0] eff_chunk;
  logic [uotc_pkg::CFG_W-1:0] eff_overlap;
  logic [uotc_pkg::CFG_W-1:0] eff_step;

  logic [31:0] byte_offset;
  logic [31:0] char_count;
  logic [31:0] next_start;
  logic [31:0] emitted;
  logic [CW-1:0] win_count;
  logic        dropped;

  logic        accept;
  logic        lead;
  logic        close;
  logic        open_due;
  logic        open_ok;
  logic        drop;
  logic        dropped_next;
  logic        emit_a;
  logic        emit_b;
  logic [CW-1:0] count_after;
  logic        q_room;
  logic [uotc_pkg::Q_CW-1:0] q_fill;

  uotc_pkg::cell_ctl_t ctl;
  uotc_pkg::slot_t     cur [N];
  uotc_pkg::slot_t     upd [N];
  uotc_pkg::result_t   rec_a;
  uotc_pkg::result_t   rec_b;
  uotc_pkg::result_t   q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_chars   <= uotc_pkg::CHUNK_RESET;
      overlap_chars <= uotc_pkg::OVERLAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        uotc_pkg::REG_CHUNK_CHARS:   chunk_chars   <= cfg_data;
        uotc_pkg::REG_OVERLAP_CHARS: overlap_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_chunk   = (chunk_chars == '0) ? uotc_pkg::CFG_W'(1) : chunk_chars;
    eff_overlap = (overlap_chars >= eff_chunk) ? eff_chunk - uotc_pkg::CFG_W'(1)
                                               : overlap_chars;
    eff_step    = eff_chunk - eff_overlap;
  end

  assign in_ready = q_room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lead        = (text_byte & uotc_pkg::LEAD_MASK) != uotc_pkg::CONT_CODE;
    close       = lead && cur[0].valid
                  && ((cur[0].start_char + 32'(eff_chunk)) == char_count);
    emit_a      = close && cur[0].seen;
    count_after = win_count - CW'(close);
    open_due    = lead && (char_count == next_start);
    open_ok     = open_due && (count_after < CW'(N));
    drop        = open_due && !open_ok;
    dropped_next = dropped || drop;
  end

  always_comb begin
    ctl.en         = accept;
    ctl.clear      = end_of_document;
    ctl.shift      = close;
    ctl.join_byte  = !uotc_pkg::is_space(text_byte);
    ctl.offset     = byte_offset;
    ctl.start_char = char_count;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    uotc_pkg::slot_t nbr;
    if (i == N - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_link
      assign nbr = cur[i+1];
    end
    uotc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .open_here (open_ok && (count_after == CW'(i))),
      .nbr       (nbr),
      .cur       (cur[i]),
      .upd       (upd[i])
    );
  end

  assign emit_b = end_of_document && upd[0].valid && upd[0].seen;

  always_comb begin
    rec_a.chunk_number   = emitted;
    rec_a.begin_offset   = cur[0].first_off;
    rec_a.end_offset     = cur[0].end_off;
    rec_a.final_chunk    = 1'b0;
    rec_a.window_dropped = dropped;
    rec_a.last_in_run    = !emit_b;
    rec_b.chunk_number   = emitted + 32'(emit_a);
    rec_b.begin_offset   = upd[0].first_off;
    rec_b.end_offset     = upd[0].end_off;
    rec_b.final_chunk    = 1'b1;
    rec_b.window_dropped = dropped_next;
    rec_b.last_in_run    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      char_count  <= '0;
      next_start  <= '0;
      emitted     <= '0;
      win_count   <= '0;
      dropped     <= 1'b0;
    end else if (accept) begin
      if (end_of_document) begin
        byte_offset <= '0;
        char_count  <= '0;
        next_start  <= '0;
        emitted     <= '0;
        win_count   <= '0;
        dropped     <= 1'b0;
      end else begin
        byte_offset <= byte_offset + 32'd1;
        char_count  <= char_count + 32'(lead);
        if (open_due) begin
          next_start <= char_count + 32'(eff_step);
        end
        emitted   <= emitted + 32'(emit_a);
        win_count <= count_after + CW'(open_ok);
        dropped   <= dropped_next;
      end
    end
  end

  uotc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_a    (accept && emit_a),
    .rec_a     (rec_a),
    .push_b    (accept && emit_b),
    .rec_b     (rec_b),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (q_head),
    .fill      (q_fill)
  );

  assign chunk_number   = q_head.chunk_number;
  assign begin_offset   = q_head.begin_offset;
  assign end_offset     = q_head.end_offset;
  assign final_chunk    = q_head.final_chunk;
  assign window_dropped = q_head.window_dropped;
  assign last_in_run    = q_head.last_in_run;

  `UOTC_ASSERT_NOW(a_count_bound, 1'b1, win_count <= CW'(N))
  `UOTC_ASSERT_NEXT(a_doc_end_clears, accept && end_of_document,
                    win_count == '0 && char_count == '0 && !cur[0].valid)
  `UOTC_ASSERT_NOW(a_pair_queued, out_valid && !last_in_run,
                   q_fill >= uotc_pkg::Q_CW'(2))
  `UOTC_ASSERT_NOW(a_drop_when_full, $rose(dropped), $past(win_count) == CW'(N))

endmodule
